// ===== hdl/cic_decimator_pruned_macros.svh =====
// assertion macros for the pruned cic decimator
// expects signals named clk and rst_n in the including scope
`ifndef CIC_DECIMATOR_PRUNED_MACROS_SVH
`define CIC_DECIMATOR_PRUNED_MACROS_SVH
`ifndef SYNTHESIS
`define CICDP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cicdp same-cycle check failed");
`define CICDP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cicdp next-cycle check failed");
`else
`define CICDP_ASSERT_IMP(lbl, ante, cons)
`define CICDP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/cicdp_pkg.sv =====
// shared widths, pruning shifts, types and the truncating divide for the cic decimator
// no dependencies
package cicdp_pkg;

    localparam int STAGES      = 4;
    localparam int ACC_WIDTH   = 48;
    localparam int IN_WIDTH    = 16;
    localparam int OUT_WIDTH   = 48;
    localparam int RATIO_WIDTH = 11;
    localparam int PHASE_WIDTH = 10;

    localparam logic [RATIO_WIDTH-1:0] RATIO_RESET = RATIO_WIDTH'(16);
    localparam logic [RATIO_WIDTH-1:0] RATIO_MAX   = RATIO_WIDTH'(1024);

    localparam int unsigned INTEG_SHIFT [STAGES] = '{0, 3, 5, 4};
    localparam int unsigned LAST_INTEG_SHIFT     = 2;
    localparam int unsigned COMB_SHIFT  [STAGES] = '{1, 1, 1, 2};

    typedef logic signed [ACC_WIDTH-1:0] acc_t;

    typedef struct packed {
        logic valid;
        logic fresh;
    } stage_ctl_t;

    typedef struct packed {
        logic                   fresh;
        logic [PHASE_WIDTH-1:0] phase;
    } phase_stat_t;

    // signed divide by 2^shift, rounding toward zero
    function automatic acc_t div_pow2_tz(acc_t value, int unsigned shift);
        logic [ACC_WIDTH-1:0] mask;
        acc_t                 floor_q;
        logic                 round_up;
        mask     = (ACC_WIDTH'(1) << shift) - ACC_WIDTH'(1);
        floor_q  = value >>> shift;
        round_up = value[ACC_WIDTH-1] && ((value & mask) != '0);
        return floor_q + acc_t'(round_up);
    endfunction

endpackage

// ===== hdl/cicdp_if.sv =====
// valid/ready channel interfaces for samples, results and the ratio register
// depends on cicdp_pkg
interface cicdp_sample_if import cicdp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [IN_WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface cicdp_result_if import cicdp_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [OUT_WIDTH-1:0] filtered_q2;
    logic                        fresh;

    modport source (output valid, output filtered_q2, output fresh, input ready);
    modport sink   (input valid, input filtered_q2, input fresh, output ready);
endinterface

interface cicdp_cfg_if import cicdp_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [RATIO_WIDTH-1:0] decimation_ratio;

    modport source (output valid, output decimation_ratio, input ready);
    modport sink   (input valid, input decimation_ratio, output ready);
endinterface

// ===== hdl/cic_decimator_pruned.sv =====
// Fourth-order CIC decimator with fixed per-stage pruning. One sample beat is taken every clock
// and every sample beat yields one result beat: the held comb output (two fractional bits) and
// a fresh flag set on the samples that ran the comb section. Each beat passes through the
// register chain of four integrators, three comb registers and the output register; each stage
// is one add. A stalled result only blocks sample beats once every stage holds a beat. Ratio
// writes take effect on the next sample and are meant to be made while the filter is idle.
// depends on cicdp_pkg, cicdp_if, cicdp_phase, cicdp_integ, cicdp_comb and the macros header
`include "cic_decimator_pruned_macros.svh"

module cic_decimator_pruned import cicdp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    cicdp_cfg_if.sink      cfg,
    cicdp_sample_if.sink   sample,
    cicdp_result_if.source result
);

    phase_stat_t stat;
    stage_ctl_t  integ_ctl;
    acc_t        integ_data;
    logic        integ_ready;
    logic        comb_ready;
    logic        accept;

    assign accept = sample.valid && integ_ready;
    assign sample.ready = integ_ready;

    cicdp_phase u_phase
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .accept (accept),
        .stat   (stat)
    );

    cicdp_integ u_integ
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sample.valid),
        .in_fresh   (stat.fresh),
        .sample_in  (sample.sample_in),
        .up_ready   (integ_ready),
        .out_ctl    (integ_ctl),
        .out_data   (integ_data),
        .down_ready (comb_ready)
    );

    cicdp_comb u_comb
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctl   (integ_ctl),
        .in_data  (integ_data),
        .up_ready (comb_ready),
        .result   (result)
    );

    // backpressure reaches the sample side only with the whole pipe full
    `CICDP_ASSERT_IMP(a_full_stall, !sample.ready, result.valid && !result.ready)
    // phase only moves on a sample beat, then steps by one or wraps
    `CICDP_ASSERT_NXT(a_phase_hold, !accept, $stable(stat.phase))
    `CICDP_ASSERT_NXT(a_phase_step, accept, stat.fresh || (stat.phase == $past(stat.phase) + 1'b1))

endmodule

// ===== hdl/cicdp_phase.sv =====
// decimation ratio register and phase counter, marks which samples run the combs
// depends on cicdp_pkg and cicdp_if
module cicdp_phase import cicdp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cicdp_cfg_if.sink   cfg,
    input  logic        accept,
    output phase_stat_t stat
);

    logic [RATIO_WIDTH-1:0] ratio_reg;
    logic [RATIO_WIDTH-1:0] ratio_eff;
    logic [PHASE_WIDTH-1:0] phase_reg;
    logic [PHASE_WIDTH-1:0] phase_next;
    logic [RATIO_WIDTH-1:0] count;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        if (ratio_reg == '0)
        begin
            ratio_eff = RATIO_WIDTH'(1);
        end
        else if (ratio_reg > RATIO_MAX)
        begin
            ratio_eff = RATIO_MAX;
        end
        else
        begin
            ratio_eff = ratio_reg;
        end
        count      = RATIO_WIDTH'(phase_reg) + RATIO_WIDTH'(1);
        phase_next = (count >= ratio_eff) ? '0 : count[PHASE_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg <= RATIO_RESET;
            phase_reg <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                ratio_reg <= cfg.decimation_ratio;
            end
            if (accept)
            begin
                phase_reg <= phase_next;
            end
        end
    end

    assign stat.fresh = (phase_reg == '0);
    assign stat.phase = phase_reg;

endmodule

// ===== hdl/cicdp_integ.sv =====
// four pruned integrator stages, each register doubling as a pipeline stage
// depends on cicdp_pkg
module cicdp_integ import cicdp_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_fresh,
    input  logic signed [IN_WIDTH-1:0] sample_in,
    output logic                       up_ready,
    output stage_ctl_t                 out_ctl,
    output acc_t                       out_data,
    input  logic                       down_ready
);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] fresh_reg;
    acc_t              integ_reg [STAGES];
    logic [STAGES:0]   rdy;
    logic [STAGES-1:0] fire;
    logic [STAGES-1:0] stage_fresh;
    acc_t              feed      [STAGES];

    always_comb
    begin
        rdy[STAGES] = down_ready;
        for (int i = STAGES - 1; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
        fire[0]        = in_valid && rdy[0];
        stage_fresh[0] = in_fresh;
        feed[0]        = div_pow2_tz(acc_t'(sample_in), INTEG_SHIFT[0]);
        for (int i = 1; i < STAGES; i++)
        begin
            fire[i]        = valid_reg[i-1] && rdy[i];
            stage_fresh[i] = fresh_reg[i-1];
            feed[i]        = div_pow2_tz(integ_reg[i-1], INTEG_SHIFT[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fresh_reg <= '0;
            for (int i = 0; i < STAGES; i++)
            begin
                integ_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                if (fire[i])
                begin
                    valid_reg[i] <= 1'b1;
                    fresh_reg[i] <= stage_fresh[i];
                    integ_reg[i] <= integ_reg[i] + feed[i];
                end
                else if (rdy[i+1])
                begin
                    valid_reg[i] <= 1'b0;
                end
            end
        end
    end

    assign up_ready      = rdy[0];
    assign out_ctl.valid = valid_reg[STAGES-1];
    assign out_ctl.fresh = fresh_reg[STAGES-1];
    assign out_data      = integ_reg[STAGES-1];

endmodule

// ===== hdl/cicdp_comb.sv =====
// four pruned comb stages, the last one holding the decimated output register
// depends on cicdp_pkg and cicdp_if
module cicdp_comb import cicdp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  stage_ctl_t      in_ctl,
    input  acc_t            in_data,
    output logic            up_ready,
    cicdp_result_if.source  result
);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] fresh_reg;
    acc_t              c_reg     [STAGES];
    acc_t              delay_reg [STAGES];
    logic [STAGES:0]   rdy;
    logic [STAGES-1:0] fire;
    logic [STAGES-1:0] stage_fresh;
    acc_t              scaled    [STAGES];

    always_comb
    begin
        rdy[STAGES] = result.ready;
        for (int i = STAGES - 1; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
        // last integrator scaling and first comb scaling truncate as one shift
        fire[0]        = in_ctl.valid && rdy[0];
        stage_fresh[0] = in_ctl.fresh;
        scaled[0]      = div_pow2_tz(in_data, LAST_INTEG_SHIFT + COMB_SHIFT[0]);
        for (int i = 1; i < STAGES; i++)
        begin
            fire[i]        = valid_reg[i-1] && rdy[i];
            stage_fresh[i] = fresh_reg[i-1];
            scaled[i]      = div_pow2_tz(c_reg[i-1], COMB_SHIFT[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fresh_reg <= '0;
            for (int i = 0; i < STAGES; i++)
            begin
                c_reg[i]     <= '0;
                delay_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                if (fire[i])
                begin
                    valid_reg[i] <= 1'b1;
                    fresh_reg[i] <= stage_fresh[i];
                    if (stage_fresh[i])
                    begin
                        c_reg[i]     <= scaled[i] - delay_reg[i];
                        delay_reg[i] <= scaled[i];
                    end
                end
                else if (rdy[i+1])
                begin
                    valid_reg[i] <= 1'b0;
                end
            end
        end
    end

    assign up_ready           = rdy[0];
    assign result.valid       = valid_reg[STAGES-1];
    assign result.fresh       = fresh_reg[STAGES-1];
    assign result.filtered_q2 = OUT_WIDTH'(c_reg[STAGES-1]);

endmodule
